// ===== rtl/core/xmodem_checksum_receiver_core_assert.svh =====
// Assertion macros for the XModem checksum receiver core.
`ifndef XMODEM_CHECKSUM_RECEIVER_CORE_ASSERT_SVH
`define XMODEM_CHECKSUM_RECEIVER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define XCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property including cycles in reset.
`define XCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define XCR_ASSERT(label, prop, msg)
`define XCR_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/core/xcr_pkg.sv =====
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared types and constants of the XModem checksum receiver.
// ----------------------------------------------------------------------------
package xcr_pkg;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_CANCEL  = 2'd1;
  localparam logic [1:0] ST_NORESP  = 2'd2;
  localparam logic [1:0] ST_TOOMANY = 2'd3;

  localparam logic [2:0] REG_START_WAIT = 3'd0;
  localparam logic [2:0] REG_BYTE_WAIT  = 3'd1;
  localparam logic [2:0] REG_FLUSH_WAIT = 3'd2;
  localparam logic [2:0] REG_ATTEMPTS   = 3'd3;
  localparam logic [2:0] REG_RETRANS    = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE, PH_POLL, PH_BLOCK, PH_FLUSH
  } phase_t;

  typedef enum logic [2:0] {
    AF_NAK, AF_DONE, AF_CANCEL, AF_NORESP, AF_TOOMANY
  } after_t;

  // Controller states
  typedef enum logic [2:0] {
    CS_IDLE,   // wait for an input item
    CS_EVAL,   // decide the item's effect
    CS_EMIT,   // present one result
    CS_READ    // fetch next buffer byte
  } ctl_state_t;

  // Result sequence selectors
  typedef enum logic [2:0] {
    SEQ_NONE, SEQ_ONE_TX, SEQ_ACK_END, SEQ_CAN_END, SEQ_WORDS_ACK
  } seq_t;

  typedef struct packed {
    logic        load_word;  // shift read byte into the word register
    logic        rd_next;    // advance the buffer read pointer
    logic        rd_clear;   // restart the buffer read pointer
  } dp_cmd_t;

  typedef struct packed {
    logic word_full;   // eight bytes gathered
    logic rd_done;     // all bytes read
  } dp_stat_t;

endpackage

// ===== rtl/core/xcr_datapath.sv =====
// ----------------------------------------------------------------------------
// xcr_datapath
// Block buffer memory and the 64-bit word assembler.
// ----------------------------------------------------------------------------
module xcr_datapath #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [$clog2(BLOCK_BYTES)-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  xcr_pkg::dp_cmd_t          cmd,
  output xcr_pkg::dp_stat_t         stat,
  output logic [63:0]               word
);
  import xcr_pkg::*;

  localparam int AW = $clog2(BLOCK_BYTES);

  logic [7:0]    mem [BLOCK_BYTES];
  logic [7:0]    rd_data;
  logic [AW:0]   rd_ptr;
  logic [3:0]    byte_cnt;

  // Write received bytes; fetch the next byte only when the pointer advances
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_next) begin
      rd_data <= mem[rd_ptr[AW-1:0]];
    end
  end

  // Advance read pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.rd_clear) begin
      rd_ptr <= '0;
    end else if (cmd.rd_next) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // Assemble words, first byte lowest
  always_ff @(posedge clk) begin
    if (rst || cmd.rd_clear) begin
      byte_cnt <= '0;
    end else if (cmd.load_word) begin
      word     <= {rd_data, word[63:8]};
      byte_cnt <= (byte_cnt == 4'd8) ? 4'd1 : byte_cnt + 4'd1;
    end
  end

  assign stat.word_full = (byte_cnt == 4'd8);
  assign stat.rd_done   = (rd_ptr == (AW+1)'(BLOCK_BYTES));

endmodule

// ===== rtl/core/xcr_controller.sv =====
// ----------------------------------------------------------------------------
// xcr_controller
// Protocol state, timers and result sequencing of the receiver.
// ----------------------------------------------------------------------------
module xcr_controller #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [23:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                opcode,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                kind,
  output logic [7:0]                tx_byte,
  output logic [63:0]               data_word,
  output logic [1:0]                end_status,
  output logic                      last,
  output logic                      wr_en,
  output logic [$clog2(BLOCK_BYTES)-1:0] wr_addr,
  output logic [7:0]                wr_data,
  output xcr_pkg::dp_cmd_t          cmd,
  input  xcr_pkg::dp_stat_t         stat,
  input  logic [63:0]               word
);
  import xcr_pkg::*;

  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int BW = $clog2(BLOCK_BYTES + 3);
  localparam logic [BW-1:0] LAST_IDX = BW'(BLOCK_BYTES + 2);

  // Configuration registers
  logic [23:0] start_wait, byte_wait, flush_wait;
  logic [7:0]  attempts, retrans_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_wait    <= 24'd2000;
      byte_wait     <= 24'd1000;
      flush_wait    <= 24'd1500;
      attempts      <= 8'd32;
      retrans_limit <= 8'd25;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_WAIT: start_wait    <= cfg_data;
        REG_BYTE_WAIT:  byte_wait     <= cfg_data;
        REG_FLUSH_WAIT: flush_wait    <= cfg_data;
        REG_ATTEMPTS:   attempts      <= cfg_data[7:0];
        REG_RETRANS:    retrans_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Protocol state
  phase_t      phase, phase_next;
  after_t      after, after_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [BW-1:0] byte_index, byte_index_next;
  logic [7:0]  expected, expected_next;
  logic [8:0]  retrans_left, retrans_left_next;
  logic [23:0] wait_timer, wait_timer_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  got_number, got_number_next;
  logic [7:0]  got_compl, got_compl_next;
  logic        send_poll, send_poll_next;

  ctl_state_t  state, state_next;
  seq_t        seq, seq_next;
  logic [1:0]  seq_pos, seq_pos_next;
  logic [7:0]  seq_tx, seq_tx_next;
  logic [1:0]  seq_status, seq_status_next;
  logic [1:0]  op_q;
  logic [7:0]  ch_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CS_IDLE;
      phase        <= PH_IDLE;
      after        <= AF_NAK;
      poll_count   <= '0;
      byte_index   <= '0;
      expected     <= 8'd1;
      retrans_left <= 9'd25;
      wait_timer   <= '0;
      running_sum  <= '0;
      got_number   <= '0;
      got_compl    <= '0;
      send_poll    <= 1'b1;
      seq          <= SEQ_NONE;
      seq_pos      <= '0;
      seq_tx       <= '0;
      seq_status   <= '0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      after        <= after_next;
      poll_count   <= poll_count_next;
      byte_index   <= byte_index_next;
      expected     <= expected_next;
      retrans_left <= retrans_left_next;
      wait_timer   <= wait_timer_next;
      running_sum  <= running_sum_next;
      got_number   <= got_number_next;
      got_compl    <= got_compl_next;
      send_poll    <= send_poll_next;
      seq          <= seq_next;
      seq_pos      <= seq_pos_next;
      seq_tx       <= seq_tx_next;
      seq_status   <= seq_status_next;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= opcode;
      ch_q <= rx_byte;
    end
  end

  logic [23:0] timer_inc;
  logic [23:0] limit;
  logic        expired;
  logic [7:0]  poll_inc;
  logic        blk_ok;
  logic        blk_new;

  always_comb begin
    timer_inc = (wait_timer == 24'hFFFFFF) ? wait_timer : wait_timer + 24'd1;
    priority case (phase)
      PH_POLL:  limit = start_wait;
      PH_BLOCK: limit = byte_wait;
      default:  limit = flush_wait;
    endcase
    expired  = (timer_inc >= limit);
    poll_inc = poll_count + 8'd1;
    blk_ok   = (got_number == ~got_compl) &&
               (got_number == expected || got_number == expected - 8'd1) &&
               (running_sum == ch_q);
    blk_new  = (got_number == expected);
  end

  // Next state, item evaluation and result sequencing
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    after_next        = after;
    poll_count_next   = poll_count;
    byte_index_next   = byte_index;
    expected_next     = expected;
    retrans_left_next = retrans_left;
    wait_timer_next   = wait_timer;
    running_sum_next  = running_sum;
    got_number_next   = got_number;
    got_compl_next    = got_compl;
    send_poll_next    = send_poll;
    seq_next          = seq;
    seq_pos_next      = seq_pos;
    seq_tx_next       = seq_tx;
    seq_status_next   = seq_status;
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    kind              = KIND_TX;
    tx_byte           = '0;
    data_word         = '0;
    end_status        = '0;
    last              = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = AW'(byte_index - BW'(2));
    wr_data           = ch_q;
    cmd               = '0;

    unique case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = CS_EVAL;
        end
      end

      CS_EVAL: begin
        state_next   = CS_IDLE;
        seq_next     = SEQ_NONE;
        seq_pos_next = '0;
        if (op_q == OP_START) begin
          expected_next     = 8'd1;
          retrans_left_next = {1'b0, retrans_limit};
          send_poll_next    = 1'b1;
          running_sum_next  = '0;
          byte_index_next   = '0;
          after_next        = AF_NAK;
          phase_next        = PH_POLL;
          poll_count_next   = '0;
          wait_timer_next   = '0;
          seq_next          = SEQ_ONE_TX;
          seq_tx_next       = CH_NAK;
        end else if (op_q == OP_BYTE) begin
          wait_timer_next = '0;
          if (phase == PH_POLL) begin
            if (ch_q == CH_SOH) begin
              phase_next       = PH_BLOCK;
              send_poll_next   = 1'b0;
              byte_index_next  = '0;
              running_sum_next = '0;
            end else if (ch_q == CH_EOT) begin
              phase_next = PH_FLUSH;
              after_next = AF_DONE;
            end else if (ch_q == CH_CAN) begin
              phase_next = PH_FLUSH;
              after_next = AF_CANCEL;
            end else begin
              poll_count_next = poll_inc;
              if (poll_inc >= attempts) begin
                phase_next = PH_FLUSH;
                after_next = AF_NORESP;
              end else if (send_poll) begin
                seq_next    = SEQ_ONE_TX;
                seq_tx_next = CH_NAK;
              end
            end
          end else if (phase == PH_BLOCK) begin
            if (byte_index == LAST_IDX) begin
              if (!blk_ok) begin
                phase_next = PH_FLUSH;
                after_next = AF_NAK;
              end else begin
                if (blk_new) begin
                  expected_next = expected + 8'd1;
                end
                if (!blk_new && retrans_left <= 9'd1) begin
                  retrans_left_next = '0;
                  phase_next        = PH_FLUSH;
                  after_next        = AF_TOOMANY;
                end else begin
                  retrans_left_next = blk_new ? {1'b0, retrans_limit}
                                              : retrans_left - 9'd1;
                  phase_next        = PH_POLL;
                  poll_count_next   = '0;
                  seq_next          = blk_new ? SEQ_WORDS_ACK : SEQ_ONE_TX;
                  seq_tx_next       = CH_ACK;
                  // limit of zero after a new block aborts after the words
                  if (blk_new && retrans_limit == 8'd0) begin
                    retrans_left_next = '0;
                    phase_next        = PH_FLUSH;
                    after_next        = AF_TOOMANY;
                  end
                end
              end
            end else begin
              if (byte_index == '0) begin
                got_number_next = ch_q;
              end else if (byte_index == BW'(1)) begin
                got_compl_next = ch_q;
              end else begin
                wr_en            = 1'b1;
                running_sum_next = running_sum + ch_q;
              end
              byte_index_next = byte_index + BW'(1);
            end
          end
        end else if (op_q == OP_TICK && phase != PH_IDLE) begin
          wait_timer_next = expired ? '0 : timer_inc;
          if (expired) begin
            unique case (phase)
              PH_POLL: begin
                poll_count_next = poll_inc;
                if (poll_inc >= attempts) begin
                  phase_next = PH_FLUSH;
                  after_next = AF_NORESP;
                end else if (send_poll) begin
                  seq_next    = SEQ_ONE_TX;
                  seq_tx_next = CH_NAK;
                end
              end
              PH_BLOCK: begin
                phase_next = PH_FLUSH;
                after_next = AF_NAK;
              end
              default: begin
                unique case (after)
                  AF_DONE, AF_CANCEL: begin
                    seq_next        = SEQ_ACK_END;
                    seq_status_next = (after == AF_DONE) ? ST_DONE : ST_CANCEL;
                    phase_next      = PH_IDLE;
                  end
                  AF_NORESP, AF_TOOMANY: begin
                    seq_next        = SEQ_CAN_END;
                    seq_status_next = (after == AF_NORESP) ? ST_NORESP : ST_TOOMANY;
                    phase_next      = PH_IDLE;
                  end
                  default: begin
                    seq_next        = SEQ_ONE_TX;
                    seq_tx_next     = CH_NAK;
                    phase_next      = PH_POLL;
                    poll_count_next = '0;
                  end
                endcase
              end
            endcase
          end
        end
        if (seq_next == SEQ_WORDS_ACK) begin
          cmd.rd_clear = 1'b1;
          state_next   = CS_READ;
        end else if (seq_next != SEQ_NONE) begin
          state_next = CS_EMIT;
        end
      end

      CS_READ: begin
        // gather one byte per cycle until a word is ready
        if (stat.word_full && seq_pos == 2'd1) begin
          state_next = CS_EMIT;
        end else begin
          cmd.load_word = (seq_pos == 2'd1);
          cmd.rd_next   = !stat.rd_done;
          seq_pos_next  = 2'd1;
        end
      end

      CS_EMIT: begin
        out_valid = 1'b1;
        unique case (seq)
          SEQ_ONE_TX: begin
            tx_byte = seq_tx;
            last    = 1'b1;
            if (out_ready) state_next = CS_IDLE;
          end
          SEQ_ACK_END: begin
            if (seq_pos == 2'd0) begin
              tx_byte = CH_ACK;
              if (out_ready) seq_pos_next = 2'd1;
            end else begin
              kind       = KIND_END;
              end_status = seq_status;
              last       = 1'b1;
              if (out_ready) state_next = CS_IDLE;
            end
          end
          SEQ_CAN_END: begin
            if (seq_pos != 2'd3) begin
              tx_byte = CH_CAN;
              if (out_ready) seq_pos_next = seq_pos + 2'd1;
            end else begin
              kind       = KIND_END;
              end_status = seq_status;
              last       = 1'b1;
              if (out_ready) state_next = CS_IDLE;
            end
          end
          SEQ_WORDS_ACK: begin
            if (seq_pos == 2'd1) begin
              kind      = KIND_WORD;
              data_word = word;
              last      = stat.rd_done && phase == PH_FLUSH;
              if (out_ready) begin
                if (!stat.rd_done) begin
                  cmd.load_word = 1'b1;
                  cmd.rd_next   = 1'b1;
                  state_next    = CS_READ;
                end else if (phase == PH_FLUSH) begin
                  state_next = CS_IDLE;
                end else begin
                  seq_pos_next = 2'd2;
                end
              end
            end else begin
              tx_byte = CH_ACK;
              last    = 1'b1;
              if (out_ready) state_next = CS_IDLE;
            end
          end
          default: state_next = CS_IDLE;
        endcase
      end

      default: state_next = CS_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/xmodem_checksum_receiver_core.sv =====
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_core
// XModem checksum receiver: polls, collects blocks, emits data words.
// ----------------------------------------------------------------------------
// An item is taken in one cycle and evaluated in the next; no new item is
// taken until every result of the last one has been accepted. A new block
// drains 16 words from the block buffer's single read port. Synchronous
// reset returns all control state and the configuration registers to their
// defaults; the buffer is not cleared.
module xmodem_checksum_receiver_core #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [63:0] data_word,
  output logic [1:0]  end_status,
  output logic        last
);
  import xcr_pkg::*;

  `include "xmodem_checksum_receiver_core_assert.svh"

  logic                          wr_en;
  logic [$clog2(BLOCK_BYTES)-1:0] wr_addr;
  logic [7:0]                    wr_data;
  dp_cmd_t                       cmd;
  dp_stat_t                      stat;
  logic [63:0]                   word;

  xcr_controller #(.BLOCK_BYTES(BLOCK_BYTES)) u_ctl (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .opcode, .rx_byte,
    .out_valid, .out_ready, .kind, .tx_byte, .data_word, .end_status, .last,
    .wr_en, .wr_addr, .wr_data, .cmd, .stat, .word
  );

  xcr_datapath #(.BLOCK_BYTES(BLOCK_BYTES)) u_dp (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .cmd, .stat, .word
  );

  // Never take an item while a result is offered
  `XCR_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken during output")
  // Data words carry no byte or status
  `XCR_ASSERT(a_word_clean, out_valid && kind == KIND_WORD |-> ~|{tx_byte, end_status}, "bad word")
  // A session end result is always the last of its item
  `XCR_ASSERT(a_end_last, !(out_valid && kind == KIND_END) || last, "end result not last")

endmodule
